// File: hw/rtl/bapg_pkg.sv
// Shared types and constants for the button-adjusted PWM generator.
// No dependencies; every other RTL file imports this package.
package bapg_pkg;

  // Cycle counter width.
  localparam int COUNT_WIDTH = 16;
  localparam int DUTY_WIDTH  = 16;
  localparam int PRE_WIDTH   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  // Compare width: wide enough for the counter, the duty and the period plus a carry.
  localparam int CMP_W = ((COUNT_WIDTH > DUTY_WIDTH) ? COUNT_WIDTH : DUTY_WIDTH) + 1;

  localparam logic [DUTY_WIDTH-1:0] PERIOD_RESET = 16'd40000;
  localparam logic [DUTY_WIDTH-1:0] STEP_RESET   = 16'd100;
  localparam logic [PRE_WIDTH-1:0]  PRE_RESET    = 8'd2;
  localparam logic [DUTY_WIDTH-1:0] DUTY_RESET   = 16'd20000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_STEP      = 2'd1,
    REG_PRESCALE  = 2'd2,
    REG_INIT_DUTY = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] period;
    logic [DUTY_WIDTH-1:0] step;
    logic [PRE_WIDTH-1:0]  prescale;
  } cfg_t;

  typedef struct packed {
    logic poll;
    logic inc;
    logic dec;
    logic onoff;
  } item_t;

  typedef struct packed {
    logic                  pwm_level;
    logic [DUTY_WIDTH-1:0] duty_value;
    logic                  is_running;
  } res_t;

endpackage

// File: hw/rtl/bapg_cfg.sv
// Configuration register file of the PWM generator.
// Depends on bapg_pkg.
module bapg_cfg import bapg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_PERIOD:    cfg_d.period   = cfg_data_i[DUTY_WIDTH-1:0];
        REG_STEP:      cfg_d.step     = cfg_data_i[DUTY_WIDTH-1:0];
        REG_PRESCALE:  cfg_d.prescale = cfg_data_i[PRE_WIDTH-1:0];
        // Reset always reloads the fixed default duty: drop the write.
        REG_INIT_DUTY: cfg_d = cfg_q;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period   <= PERIOD_RESET;
      cfg_q.step     <= STEP_RESET;
      cfg_q.prescale <= PRE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/bapg_step.sv
// Timer and button state of the PWM generator, advanced once per tick.
// Depends on bapg_pkg.
module bapg_step import bapg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [PRE_WIDTH-1:0]   pre_cnt_q, pre_cnt_d;
  logic [COUNT_WIDTH-1:0] cyc_cnt_q, cyc_cnt_d;
  logic [DUTY_WIDTH-1:0]  duty_wr_q, duty_wr_d;
  logic [DUTY_WIDTH-1:0]  duty_act_q, duty_act_d;
  logic                   latch_q, latch_d;
  logic                   run_q, run_d;
  logic                   stop_q, stop_d;
  logic                   rel_q, rel_d;

  logic                   poll_ok;
  logic [DUTY_WIDTH:0]    inc_sum;
  logic [DUTY_WIDTH-1:0]  duty_inc;
  logic [CMP_W-1:0]       cyc_ext, cyc_next, duty_act_ext, period_ext;

  always_comb begin
    pre_cnt_d  = pre_cnt_q;
    cyc_cnt_d  = cyc_cnt_q;
    duty_wr_d  = duty_wr_q;
    duty_act_d = duty_act_q;
    latch_d    = latch_q;
    run_d      = run_q;
    stop_d     = stop_q;
    rel_d      = rel_q;

    if (rel_q && !stop_q && !item_i.onoff) begin
      rel_d = 1'b0;
    end
    poll_ok = item_i.poll && !stop_q && !rel_d;

    inc_sum  = {1'b0, duty_wr_q} + {1'b0, cfg_i.step};
    duty_inc = duty_wr_q;
    if (poll_ok && item_i.inc && (inc_sum < {1'b0, cfg_i.period})) begin
      duty_inc = inc_sum[DUTY_WIDTH-1:0];
    end
    duty_wr_d = duty_inc;
    if (poll_ok && item_i.dec && (duty_inc > cfg_i.step)) begin
      duty_wr_d = duty_inc - cfg_i.step;
    end
    if (poll_ok && (item_i.inc || item_i.dec)) begin
      latch_d = 1'b1;
    end
    if (poll_ok && item_i.onoff) begin
      if (!run_q) run_d = 1'b1;
      else        stop_d = 1'b1;
      rel_d = 1'b1;
    end

    cyc_ext      = CMP_W'(cyc_cnt_q);
    duty_act_ext = CMP_W'(duty_act_q);
    period_ext   = CMP_W'(cfg_i.period);
    cyc_next     = cyc_ext + CMP_W'(1);

    // Stop only once the output has gone low.
    if (stop_d && (cyc_ext >= duty_act_ext)) begin
      run_d  = 1'b0;
      stop_d = 1'b0;
    end

    if (run_d) begin
      if (pre_cnt_q >= cfg_i.prescale) begin
        pre_cnt_d = '0;
        if (cyc_next >= period_ext) begin
          cyc_cnt_d = '0;
          if (latch_d) begin
            duty_act_d = duty_wr_d;
            latch_d    = 1'b0;
          end
        end else begin
          cyc_cnt_d = cyc_next[COUNT_WIDTH-1:0];
        end
      end else begin
        pre_cnt_d = pre_cnt_q + PRE_WIDTH'(1);
      end
    end
  end

  always_comb begin
    res_o.pwm_level  = run_d && (CMP_W'(cyc_cnt_d) < CMP_W'(duty_act_d));
    res_o.duty_value = duty_wr_d;
    res_o.is_running = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q  <= '0;
      cyc_cnt_q  <= '0;
      duty_wr_q  <= DUTY_RESET;
      duty_act_q <= DUTY_RESET;
      latch_q    <= 1'b0;
      run_q      <= 1'b1;
      stop_q     <= 1'b0;
      rel_q      <= 1'b0;
    end else if (en_i) begin
      pre_cnt_q  <= pre_cnt_d;
      cyc_cnt_q  <= cyc_cnt_d;
      duty_wr_q  <= duty_wr_d;
      duty_act_q <= duty_act_d;
      latch_q    <= latch_d;
      run_q      <= run_d;
      stop_q     <= stop_d;
      rel_q      <= rel_d;
    end
  end

endmodule

// File: hw/rtl/button_adjusted_pwm_generator.sv
// Top level of the button-adjusted PWM generator: input register, output register.
// Depends on bapg_pkg, bapg_cfg and bapg_step.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------------
//   in      | in_valid_i / in_stall_o | poll_strobe_i, btn_increase_i,
//           |                         | btn_decrease_i, btn_onoff_i
//   out     | out_valid_o/out_stall_i | pwm_level_o, duty_value_o, is_running_o
//   cfg     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One tick per cycle while the output is not stalled: a transfer lands in the
// input register, then the timer state advances and the result lands in the
// output register.
// Reset (async, active low) restores the register defaults and starts running.
// A stalled output holds the result; the input register then holds its tick and
// raises in_stall_o until the output register drains.
module button_adjusted_pwm_generator import bapg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  poll_strobe_i,
  input  logic                  btn_increase_i,
  input  logic                  btn_decrease_i,
  input  logic                  btn_onoff_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  pwm_level_o,
  output logic [DUTY_WIDTH-1:0] duty_value_o,
  output logic                  is_running_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t item_q, item_d;
  logic  in_vld_q;
  res_t  res_step, res_q;
  logic  out_vld_q;
  logic  out_free;
  logic  advance;
  logic  in_load;

  bapg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Output slot frees up when empty or when its result is taken this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  // Advance the timer with the registered tick whenever its result has a slot.
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.poll  = poll_strobe_i;
    item_d.inc   = btn_increase_i;
    item_d.dec   = btn_decrease_i;
    item_d.onoff = btn_onoff_i;
  end

  bapg_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_step)
  );

  // Input register: take a new tick whenever not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q <= item_d;
    end
  end

  // Output register: hold the result while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_step;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pwm_level_o  = res_q.pwm_level;
  assign duty_value_o = res_q.duty_value;
  assign is_running_o = res_q.is_running;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_adjusted_pwm_generator: directed button, wrap,
// on/off, prescaler cases, then random button sessions. Uses bapg_pkg and the DUT.
module tb_top;
  import bapg_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int ITEM_TARGET = 1950;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  poll_strobe_i  = 1'b0;
  logic                  btn_increase_i = 1'b0;
  logic                  btn_decrease_i = 1'b0;
  logic                  btn_onoff_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  pwm_level_o;
  logic [DUTY_WIDTH-1:0] duty_value_o;
  logic                  is_running_o;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  button_adjusted_pwm_generator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .poll_strobe_i  (poll_strobe_i),
    .btn_increase_i (btn_increase_i),
    .btn_decrease_i (btn_decrease_i),
    .btn_onoff_i    (btn_onoff_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pwm_level_o    (pwm_level_o),
    .duty_value_o   (duty_value_o),
    .is_running_o   (is_running_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Timer model: register shadow plus the full timer state, advanced once per
  // accepted tick in transfer order.
  // ---------------------------------------------------------------------------
  logic [DUTY_WIDTH-1:0]  cfg_period, cfg_step;
  logic [PRE_WIDTH-1:0]   cfg_pre;
  logic [PRE_WIDTH-1:0]   pre_cnt;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [DUTY_WIDTH-1:0]  duty_wr, duty_act;
  logic                   latch_req, running, stop_pend, rel_wait;

  res_t pwm_expected[$];
  res_t head;

  int n_fail, n_items, n_results, n_writes, n_latches, n_stops, n_starts, n_sessions;
  int n_cycles;

  // Source and sink idling, switched per session so some stretches run flat out.
  bit src_idle, sink_idle;
  int out_hold;

  // Held-button counters for the well-formed random sessions.
  int hold_inc, hold_dec, hold_onoff, poll_every, poll_phase;

  function automatic res_t pwm_tick(item_t t);
    res_t             r;
    logic [CMP_W-1:0] sum;
    // Release of the on/off button unblocks polling, but not while a stop waits.
    if (rel_wait && !stop_pend && !t.onoff) rel_wait = 1'b0;
    if (t.poll && !stop_pend && !rel_wait) begin
      if (t.inc) begin
        sum = CMP_W'(duty_wr) + CMP_W'(cfg_step);
        if (sum < CMP_W'(cfg_period)) duty_wr = sum[DUTY_WIDTH-1:0];
        latch_req = 1'b1;
      end
      if (t.dec) begin
        if (duty_wr > cfg_step) duty_wr = duty_wr - cfg_step;
        latch_req = 1'b1;
      end
      if (t.onoff) begin
        if (!running) begin
          running = 1'b1;
          n_starts++;
        end else begin
          stop_pend = 1'b1;
        end
        rel_wait = 1'b1;
      end
    end
    // Stop only once the output would be low.
    if (stop_pend && cnt >= duty_act) begin
      running   = 1'b0;
      stop_pend = 1'b0;
      n_stops++;
    end
    if (running) begin
      if (pre_cnt >= cfg_pre) begin
        pre_cnt = '0;
        if (CMP_W'(cnt) + 1 >= CMP_W'(cfg_period)) begin
          cnt = '0;
          if (latch_req) begin
            duty_act  = duty_wr;
            latch_req = 1'b0;
            n_latches++;
          end
        end else begin
          cnt = cnt + 1'b1;
        end
      end else begin
        pre_cnt = pre_cnt + 1'b1;
      end
    end
    r.pwm_level  = running && (cnt < duty_act);
    r.duty_value = duty_wr;
    r.is_running = running;
    return r;
  endfunction

  // A stop may only be requested when the count is sure to reach the active duty
  // soon; otherwise polling would stay blocked for good.
  function automatic bit stop_safe();
    if (!running) return 1'b1;
    if (duty_act < cfg_period && (int'(duty_act) + 1) * (int'(cfg_pre) + 1) <= 512)
      return 1'b1;
    return latch_req && duty_wr < cfg_period &&
           (int'(cfg_period) + int'(duty_wr)) * (int'(cfg_pre) + 1) <= 2048;
  endfunction

  function automatic item_t buttons(bit poll, bit inc, bit dec, bit onoff);
    item_t t;
    t.poll  = poll;
    t.inc   = inc;
    t.dec   = dec;
    t.onoff = onoff;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, transfers are seen on the rising.
  // ---------------------------------------------------------------------------
  task automatic send_tick(item_t t);
    int gap;
    @(negedge clk_i);
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    poll_strobe_i  <= t.poll;
    btn_increase_i <= t.inc;
    btn_decrease_i <= t.dec;
    btn_onoff_i    <= t.onoff;
    // Hold the tick until the block takes it, then predict its result.
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pwm_expected.push_back(pwm_tick(t));
    n_items++;
  endtask

  // Drop valid and wait until every pending result has drained.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pwm_expected.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_PERIOD:    cfg_period = data;
      REG_STEP:      cfg_step   = data;
      REG_PRESCALE:  cfg_pre    = data[PRE_WIDTH-1:0];
      // The initial duty only matters at reset, and reset restores its default.
      REG_INIT_DUTY: ;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_writes++;
  endtask

  task automatic reconfigure(int period, int step, int pre);
    settle();
    write_reg(REG_PERIOD, period[CFG_DATA_W-1:0]);
    write_reg(REG_STEP, step[CFG_DATA_W-1:0]);
    write_reg(REG_PRESCALE, pre[CFG_DATA_W-1:0]);
  endtask

  // Tick until a pending stop has taken effect, so the next settings start clean.
  task automatic wait_stopped();
    while (stop_pend) send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // Receiver: stall a drawn number of cycles after each transfer.
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each transferred result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pwm_expected.size() == 0) begin
        $error("result transferred with no tick pending");
        n_fail++;
      end else begin
        head = pwm_expected.pop_front();
        if (pwm_level_o !== head.pwm_level) begin
          $error("pwm_level: expected %0d, got %0d", head.pwm_level, pwm_level_o);
          n_fail++;
        end
        if (duty_value_o !== head.duty_value) begin
          $error("duty_value: expected %0d, got %0d", head.duty_value, duty_value_o);
          n_fail++;
        end
        if (is_running_o !== head.is_running) begin
          $error("is_running: expected %0d, got %0d", head.is_running, is_running_o);
          n_fail++;
        end
      end
      n_results++;
      out_hold = sink_idle ? $urandom_range(0, 8) : 0;
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles,
               pwm_expected.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Defaults after reset: idle ticks, buttons without a poll, one-step moves.
  task automatic test_reset_defaults();
    send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(buttons(1'b0, 1'b1, 1'b1, 1'b1));
    send_tick(buttons(1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(buttons(1'b1, 1'b0, 1'b1, 1'b0));
    send_tick(buttons(1'b1, 1'b1, 1'b1, 1'b0));
  endtask

  // Both rejection edges: sum equal to period, duty equal to step; then the
  // widest step, then a large step that drops the duty near zero.
  task automatic test_duty_limits();
    reconfigure(40000, 20000, 2);
    send_tick(buttons(1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(buttons(1'b1, 1'b0, 1'b1, 1'b0));
    settle();
    write_reg(REG_STEP, 16'hFFFF);
    send_tick(buttons(1'b1, 1'b1, 1'b1, 1'b0));
    settle();
    write_reg(REG_STEP, 16'd19997);
    send_tick(buttons(1'b1, 1'b0, 1'b1, 1'b0));
  endtask

  // Short period: wraps copy the shadowed duty, increase stops below period.
  task automatic test_wrap_latch();
    reconfigure(6, 1, 0);
    repeat (5) send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
    repeat (3) send_tick(buttons(1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  // Stop request with the button held, blocked polls, duty change while
  // stopped, restart.
  task automatic test_onoff_sequence();
    while (!stop_safe()) send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(buttons(1'b1, 1'b0, 1'b0, 1'b1));
    send_tick(buttons(1'b1, 1'b1, 1'b0, 1'b1));
    send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
    wait_stopped();
    send_tick(buttons(1'b1, 1'b0, 1'b1, 1'b0));
    send_tick(buttons(1'b1, 1'b0, 1'b0, 1'b1));
    send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // Widest period and prescaler, prescaler lowered below its count, period
  // lowered below the count, and the initial duty register at both ends.
  task automatic test_prescale_and_shrink();
    reconfigure(65535, 65535, 255);
    write_reg(REG_INIT_DUTY, 16'hFFFF);
    repeat (3) send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
    settle();
    write_reg(REG_PRESCALE, 16'd1);
    repeat (2) send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
    reconfigure(1, 1, 0);
    write_reg(REG_INIT_DUTY, 16'h0000);
    send_tick(buttons(1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(buttons(1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // One session tick: mostly held buttons polled at a steady rate, some noise.
  function automatic item_t next_press();
    item_t t;
    if ($urandom_range(0, 9) == 0) begin
      t = buttons(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      t.poll     = (poll_phase == 0);
      poll_phase = (poll_phase + 1) % poll_every;
      if (hold_inc == 0 && $urandom_range(0, 5) == 0) hold_inc = $urandom_range(1, 6);
      if (hold_dec == 0 && $urandom_range(0, 5) == 0) hold_dec = $urandom_range(1, 6);
      if (hold_onoff == 0 && $urandom_range(0, 11) == 0)
        hold_onoff = $urandom_range(1, 4);
      t.inc   = (hold_inc > 0);
      t.dec   = (hold_dec > 0);
      t.onoff = (hold_onoff > 0);
      if (hold_inc > 0) hold_inc--;
      if (hold_dec > 0) hold_dec--;
      if (hold_onoff > 0) hold_onoff--;
    end
    // Suppress a stop request that could never complete.
    if (t.onoff && t.poll && !stop_pend && !rel_wait && !stop_safe()) t.onoff = 1'b0;
    return t;
  endfunction

  // Random sessions: new settings, an optional one-poll pull of the duty into
  // range, then a run of button activity.
  task automatic test_random_sessions();
    int period, step, pre, len, target;
    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        period = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
        step   = $urandom_range(0, 1) ? 1 : 65535;
        pre    = $urandom_range(0, 1) ? 0 : 255;
      end else begin
        period = $urandom_range(1, 48);
        step   = $urandom_range(1, period);
        pre    = $urandom_range(0, 3);
      end
      settle();
      write_reg(REG_PERIOD, period[CFG_DATA_W-1:0]);
      write_reg(REG_PRESCALE, pre[CFG_DATA_W-1:0]);
      if (cfg_period >= 2 && duty_wr >= cfg_period && $urandom_range(0, 3) != 0) begin
        target = $urandom_range(1, int'(cfg_period) - 1);
        write_reg(REG_STEP, duty_wr - target[DUTY_WIDTH-1:0]);
        send_tick(buttons(1'b1, 1'b0, 1'b1, 1'b0));
        settle();
      end
      write_reg(REG_STEP, step[CFG_DATA_W-1:0]);
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_INIT_DUTY, CFG_DATA_W'($urandom_range(0, 65535)));
      src_idle   = 1'($urandom_range(0, 1));
      sink_idle  = 1'($urandom_range(0, 1));
      poll_every = $urandom_range(1, 4);
      poll_phase = 0;
      len = $urandom_range(30, 150);
      repeat (len) send_tick(next_press());
      wait_stopped();
      n_sessions++;
    end
  endtask

  initial begin
    // Timer model at its reset state.
    cfg_period = PERIOD_RESET;
    cfg_step   = STEP_RESET;
    cfg_pre    = PRE_RESET;
    pre_cnt    = '0;
    cnt        = '0;
    duty_wr    = DUTY_RESET;
    duty_act   = DUTY_RESET;
    latch_req  = 1'b0;
    running    = 1'b1;
    stop_pend  = 1'b0;
    rel_wait   = 1'b0;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_duty_limits();
    test_wrap_latch();
    test_onoff_sequence();
    test_prescale_and_shrink();
    test_random_sessions();

    settle();
    repeat (4) @(negedge clk_i);
    $display("Checked %0d results from %0d ticks over %0d random sessions, %0d writes.",
             n_results, n_items, n_sessions, n_writes);
    $display("Covered %0d duty latches, %0d stops and %0d restarts.",
             n_latches, n_stops, n_starts);
    if (n_fail == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bapg_pkg.sv
hw/rtl/bapg_cfg.sv
hw/rtl/bapg_step.sv
hw/rtl/button_adjusted_pwm_generator.sv
tb/sv/tb_top.sv
